[rtl/text_cell_page_engine_assert.svh]
// Assertion helpers for the text cell page engine.
`ifndef TEXT_CELL_PAGE_ENGINE_ASSERT_SVH
`define TEXT_CELL_PAGE_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define TCPE_ASSERT_IMP(label, clk_s, rst_ns, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_ns) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define TCPE_ASSERT_NXT(label, clk_s, rst_ns, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_ns) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/tcpe_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tcpe_pkg;

	// Page geometry
	localparam int MAX_COLS   = 128;
	localparam int MAX_ROWS   = 32;
	localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam int X_W        = $clog2(MAX_COLS);
	localparam int Y_W        = $clog2(MAX_ROWS);

	// Fixed field widths
	localparam int CMD_W   = 4;
	localparam int CRD_W   = 9;
	localparam int SHX_W   = 9;
	localparam int SHY_W   = 7;
	localparam int BYTE_W  = 8;
	localparam int CELL_W  = 2 * BYTE_W;
	localparam int COL_W   = 8;
	localparam int ROW_W   = 6;
	localparam int CUR_W   = 12;
	localparam int CFG_I_W = 1;
	localparam int CFG_D_W = 8;

	// Box bounds and source coordinates after the shift
	localparam int SB_W = 11;
	localparam logic signed [SB_W-1:0] BOX_MIN = {1'b1, {(SB_W-1){1'b0}}};
	localparam logic signed [SB_W-1:0] BOX_MAX = {1'b0, {(SB_W-1){1'b1}}};

	// Blank cell: space glyph, colour 0x0A (colour in the high byte)
	localparam logic [BYTE_W-1:0] BLANK_GLYPH  = 8'h20;
	localparam logic [BYTE_W-1:0] BLANK_COLOUR = 8'h0A;
	localparam logic [CELL_W-1:0] BLANK_CELL   = {BLANK_COLOUR, BLANK_GLYPH};

	// Reset values of the page size registers
	localparam logic [COL_W-1:0] COLS_RESET = 8'd80;
	localparam logic [ROW_W-1:0] ROWS_RESET = 6'd25;

	// Configuration register indexes
	localparam logic [CFG_I_W-1:0] REG_PAGE_COLS = 1'b0;
	localparam logic [CFG_I_W-1:0] REG_PAGE_ROWS = 1'b1;

	// Command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_PUT_BOTH   = 4'd0,
		CMD_PUT_GLYPH  = 4'd1,
		CMD_PUT_COLOUR = 4'd2,
		CMD_FILL       = 4'd3,
		CMD_COPY       = 4'd4,
		CMD_CLEAR      = 4'd5,
		CMD_CLEAR_ROW  = 4'd6,
		CMD_CURSOR     = 4'd7,
		CMD_SCROLL     = 4'd8,
		CMD_READ       = 4'd9
	} cmd_t;

	// One write and one read request to the cell memory
	typedef struct packed {
		logic              wen;
		logic [ADDR_W-1:0] waddr;
		logic [CELL_W-1:0] wdata;
		logic              ren;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

	// Result and status from the sequencer
	typedef struct packed {
		logic              push;
		logic              clearing;
		logic [BYTE_W-1:0] glyph;
		logic [BYTE_W-1:0] colour;
		logic [CUR_W-1:0]  cursor;
	} seq_res_t;

	function automatic logic signed [SB_W-1:0] sext_crd(input logic signed [CRD_W-1:0] v);
		return {{(SB_W-CRD_W){v[CRD_W-1]}}, v};
	endfunction

endpackage

`default_nettype wire

[rtl/tcpe_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// Command channel
interface tcpe_req_if;
	logic                                 valid;
	logic                                 ready;
	logic [tcpe_pkg::CMD_W-1:0]           cmd;
	logic signed [tcpe_pkg::CRD_W-1:0]    x_first;
	logic signed [tcpe_pkg::CRD_W-1:0]    y_first;
	logic signed [tcpe_pkg::CRD_W-1:0]    x_last;
	logic signed [tcpe_pkg::CRD_W-1:0]    y_last;
	logic signed [tcpe_pkg::SHX_W-1:0]    shift_x;
	logic signed [tcpe_pkg::SHY_W-1:0]    shift_y;
	logic [tcpe_pkg::BYTE_W-1:0]          glyph;
	logic [tcpe_pkg::BYTE_W-1:0]          colour;

	modport source (output valid, cmd, x_first, y_first, x_last, y_last, shift_x, shift_y,
		glyph, colour, input ready);
	modport sink (input valid, cmd, x_first, y_first, x_last, y_last, shift_x, shift_y,
		glyph, colour, output ready);
endinterface

// Result channel
interface tcpe_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        done_res;
	logic [tcpe_pkg::BYTE_W-1:0] read_glyph;
	logic [tcpe_pkg::BYTE_W-1:0] read_colour;
	logic [tcpe_pkg::CUR_W-1:0]  cursor_pos;

	modport source (output valid, done_res, read_glyph, read_colour, cursor_pos, input ready);
	modport sink (input valid, done_res, read_glyph, read_colour, cursor_pos, output ready);
endinterface

// Configuration write channel
interface tcpe_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [tcpe_pkg::CFG_I_W-1:0] index;
	logic [tcpe_pkg::CFG_D_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/tcpe_cell_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

// Cell memory: one write port, one read port, registered read data
module tcpe_cell_ram (
	input  logic                            clk,
	input  tcpe_pkg::ram_req_t              req,
	output logic [tcpe_pkg::CELL_W-1:0]     rdata
);

	logic [tcpe_pkg::CELL_W-1:0] mem [tcpe_pkg::CELL_COUNT];
	logic [tcpe_pkg::CELL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.wen) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.ren) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[rtl/tcpe_seq.sv]
`timescale 1ns / 1ps
`default_nettype none

// Command sequencer: clears the memory after reset, decodes an item, walks the
// page, touches one cell or sets the cursor, and drives the cell memory ports.
module tcpe_seq (
	input  logic                            clk,
	input  logic                            arst_n,
	tcpe_req_if.sink                        req,
	input  logic [tcpe_pkg::COL_W-1:0]      cols,
	input  logic [tcpe_pkg::ROW_W-1:0]      rows,
	input  logic                            res_free,
	input  logic [tcpe_pkg::CELL_W-1:0]     ram_rdata,
	output tcpe_pkg::ram_req_t              ram_req,
	output tcpe_pkg::seq_res_t              res
);

	localparam int SB_W   = tcpe_pkg::SB_W;
	localparam int ADDR_W = tcpe_pkg::ADDR_W;
	localparam int X_W    = tcpe_pkg::X_W;
	localparam int Y_W    = tcpe_pkg::Y_W;
	localparam int COL_W  = tcpe_pkg::COL_W;
	localparam int ROW_W  = tcpe_pkg::ROW_W;
	localparam int CRD_W  = tcpe_pkg::CRD_W;
	localparam int SHX_W  = tcpe_pkg::SHX_W;
	localparam int SHY_W  = tcpe_pkg::SHY_W;
	localparam int CELL_W = tcpe_pkg::CELL_W;
	localparam int BYTE_W = tcpe_pkg::BYTE_W;

	typedef enum logic [8:0] {
		S_CLEAR = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_SETUP = 9'b000000100,
		S_START = 9'b000001000,
		S_WALK  = 9'b000010000,
		S_DRAIN = 9'b000100000,
		S_PT_RD = 9'b001000000,
		S_PT_WR = 9'b010000000,
		S_DONE  = 9'b100000000
	} state_t;

	state_t state_q;
	logic [ADDR_W-1:0] clr_q;

	// Item latched at acceptance
	logic [tcpe_pkg::CMD_W-1:0] cmd_q;
	logic signed [CRD_W-1:0]    x1_q, y1_q;
	logic signed [SB_W-1:0]     bx1_q, bx2_q, by1_q, by2_q;
	logic signed [SHX_W-1:0]    shx_q;
	logic signed [SHY_W-1:0]    shy_q;
	logic [CELL_W-1:0]          fill_q;
	logic                       copy_q, dn_q;

	// Setup results
	logic              pt_ok_q;
	logic [ADDR_W-1:0] lin_q, last_q, off_q;

	// Walk position
	logic [X_W-1:0]    x_q;
	logic [Y_W-1:0]    y_q;
	logic [ADDR_W-1:0] idx_q;

	// Write stage
	logic              wr_vld_s1, wr_src_s1;
	logic [ADDR_W-1:0] wr_addr_s1;
	logic [CELL_W-1:0] wr_const_s1;

	logic [BYTE_W-1:0]          rg_q, rc_q;
	logic [tcpe_pkg::CUR_W-1:0] cursor_q;

	// Decode of the offered item
	logic signed [SB_W-1:0]  d_bx1, d_bx2, d_by1, d_by2;
	logic signed [SHX_W-1:0] d_shx;
	logic signed [SHY_W-1:0] d_shy;
	logic [CELL_W-1:0]       d_fill;
	logic                    d_copy, d_dn;

	always_comb begin
		d_bx1  = tcpe_pkg::sext_crd(req.x_first);
		d_bx2  = tcpe_pkg::sext_crd(req.x_last);
		d_by1  = tcpe_pkg::sext_crd(req.y_first);
		d_by2  = tcpe_pkg::sext_crd(req.y_last);
		d_shx  = '0;
		d_shy  = '0;
		d_fill = {req.colour, req.glyph};
		d_copy = 1'b0;
		unique case (req.cmd)
			tcpe_pkg::CMD_COPY: begin
				d_shx  = req.shift_x;
				d_shy  = req.shift_y;
				d_copy = 1'b1;
			end
			tcpe_pkg::CMD_CLEAR: begin
				d_bx1  = tcpe_pkg::BOX_MIN;
				d_bx2  = tcpe_pkg::BOX_MAX;
				d_by1  = tcpe_pkg::BOX_MIN;
				d_by2  = tcpe_pkg::BOX_MAX;
				d_fill = tcpe_pkg::BLANK_CELL;
			end
			tcpe_pkg::CMD_CLEAR_ROW: begin
				d_bx1  = tcpe_pkg::BOX_MIN;
				d_bx2  = tcpe_pkg::BOX_MAX;
				d_by2  = tcpe_pkg::sext_crd(req.y_first);
				d_fill = tcpe_pkg::BLANK_CELL;
			end
			tcpe_pkg::CMD_SCROLL: begin
				d_bx1  = tcpe_pkg::BOX_MIN;
				d_bx2  = tcpe_pkg::BOX_MAX;
				d_by1  = tcpe_pkg::BOX_MIN;
				d_by2  = tcpe_pkg::BOX_MAX;
				d_shx  = req.shift_x;
				d_shy  = req.shift_y;
				d_copy = 1'b1;
			end
			default: ;
		endcase
		// copy towards higher addresses walks downwards so sources are read first
		d_dn = d_copy && ((d_shy > 0) || ((d_shy == 0) && (d_shx > 0)));
	end

	// Setup arithmetic: cell index, last page index, linear copy offset
	logic                         pt_ok_d;
	logic [Y_W+COL_W-1:0]         lin_prod;
	logic [ROW_W+COL_W-1:0]       area_prod;
	logic signed [SHY_W+COL_W:0]  off_prod;
	logic [ADDR_W-1:0]            lin_d, last_d, off_d;

	always_comb begin
		pt_ok_d = !x1_q[CRD_W-1] && !y1_q[CRD_W-1]
			&& (x1_q < $signed({{(CRD_W-COL_W){1'b0}}, cols}))
			&& (y1_q < $signed({{(CRD_W-ROW_W){1'b0}}, rows}));
		lin_prod  = y1_q[Y_W-1:0] * cols;
		lin_d     = lin_prod[ADDR_W-1:0] + {{(ADDR_W-X_W){1'b0}}, x1_q[X_W-1:0]};
		area_prod = rows * cols;
		last_d    = area_prod[ADDR_W-1:0] - 1'b1;
		off_prod  = shy_q * $signed({1'b0, cols});
		off_d     = off_prod[ADDR_W-1:0] + {{(ADDR_W-SHX_W){shx_q[SHX_W-1]}}, shx_q};
	end

	// Page bounds
	logic [COL_W-1:0] cols_m1;
	logic [ROW_W-1:0] rows_m1;
	logic [X_W-1:0]   x_end;
	logic [Y_W-1:0]   y_end;
	logic             page_empty;

	assign cols_m1    = cols - 1'b1;
	assign rows_m1    = rows - 1'b1;
	assign x_end      = cols_m1[X_W-1:0];
	assign y_end      = rows_m1[Y_W-1:0];
	assign page_empty = (cols == '0) || (rows == '0);

	// Walk step: source cell of the current destination and box test
	logic signed [SB_W-1:0] sx, sy;
	logic                   in_box, src_ok, use_src, last_step;
	logic [ADDR_W-1:0]      src_idx;

	always_comb begin
		sx = {{(SB_W-X_W){1'b0}}, x_q} - {{(SB_W-SHX_W){shx_q[SHX_W-1]}}, shx_q};
		sy = {{(SB_W-Y_W){1'b0}}, y_q} - {{(SB_W-SHY_W){shy_q[SHY_W-1]}}, shy_q};
		in_box = (sx >= bx1_q) && (sx <= bx2_q) && (sy >= by1_q) && (sy <= by2_q);
		src_ok = !sx[SB_W-1] && !sy[SB_W-1]
			&& (sx < $signed({{(SB_W-COL_W){1'b0}}, cols}))
			&& (sy < $signed({{(SB_W-ROW_W){1'b0}}, rows}));
		use_src   = copy_q && in_box && src_ok;
		src_idx   = idx_q - off_q;
		last_step = dn_q ? ((x_q == '0) && (y_q == '0)) : ((x_q == x_end) && (y_q == y_end));
	end

	logic is_put;
	assign is_put = (cmd_q == tcpe_pkg::CMD_PUT_BOTH) || (cmd_q == tcpe_pkg::CMD_PUT_GLYPH)
		|| (cmd_q == tcpe_pkg::CMD_PUT_COLOUR);

	// Read-modify-write of one cell
	logic [CELL_W-1:0] merged;
	always_comb begin
		merged = ram_rdata;
		if (cmd_q != tcpe_pkg::CMD_PUT_COLOUR) begin
			merged[BYTE_W-1:0] = fill_q[BYTE_W-1:0];
		end
		if (cmd_q != tcpe_pkg::CMD_PUT_GLYPH) begin
			merged[CELL_W-1:BYTE_W] = fill_q[CELL_W-1:BYTE_W];
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			wr_vld_s1 <= 1'b0;
			cursor_q  <= '0;
		end else begin
			wr_vld_s1 <= (state_q == S_WALK) && in_box;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_SETUP;
					end
				end
				S_SETUP: state_q <= S_START;
				S_START: begin
					unique case (cmd_q)
						tcpe_pkg::CMD_PUT_BOTH, tcpe_pkg::CMD_PUT_GLYPH,
						tcpe_pkg::CMD_PUT_COLOUR, tcpe_pkg::CMD_READ: begin
							state_q <= pt_ok_q ? S_PT_RD : S_DONE;
						end
						tcpe_pkg::CMD_CURSOR: begin
							if (pt_ok_q) begin
								cursor_q <= tcpe_pkg::CUR_W'(lin_q);
							end
							state_q <= S_DONE;
						end
						tcpe_pkg::CMD_FILL, tcpe_pkg::CMD_COPY, tcpe_pkg::CMD_CLEAR,
						tcpe_pkg::CMD_CLEAR_ROW, tcpe_pkg::CMD_SCROLL: begin
							state_q <= page_empty ? S_DONE : S_WALK;
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_WALK: begin
					if (last_step) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: state_q <= S_DONE;
				S_PT_RD: state_q <= S_PT_WR;
				S_PT_WR: state_q <= S_DONE;
				S_DONE: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && req.valid) begin
			cmd_q  <= req.cmd;
			x1_q   <= req.x_first;
			y1_q   <= req.y_first;
			bx1_q  <= d_bx1;
			bx2_q  <= d_bx2;
			by1_q  <= d_by1;
			by2_q  <= d_by2;
			shx_q  <= d_shx;
			shy_q  <= d_shy;
			fill_q <= d_fill;
			copy_q <= d_copy;
			dn_q   <= d_dn;
		end
		if (state_q == S_SETUP) begin
			pt_ok_q <= pt_ok_d;
			lin_q   <= lin_d;
			last_q  <= last_d;
			off_q   <= off_d;
			rg_q    <= '0;
			rc_q    <= '0;
		end
		// walk start position
		if (state_q == S_START) begin
			if (dn_q) begin
				x_q   <= x_end;
				y_q   <= y_end;
				idx_q <= last_q;
			end else begin
				x_q   <= '0;
				y_q   <= '0;
				idx_q <= '0;
			end
		end
		if (state_q == S_WALK) begin
			if (dn_q) begin
				if (x_q == '0) begin
					x_q <= x_end;
					y_q <= y_q - 1'b1;
				end else begin
					x_q <= x_q - 1'b1;
				end
				idx_q <= idx_q - 1'b1;
			end else begin
				if (x_q == x_end) begin
					x_q <= '0;
					y_q <= y_q + 1'b1;
				end else begin
					x_q <= x_q + 1'b1;
				end
				idx_q <= idx_q + 1'b1;
			end
		end
		wr_src_s1   <= use_src;
		wr_addr_s1  <= idx_q;
		wr_const_s1 <= copy_q ? '0 : fill_q;
		if ((state_q == S_PT_WR) && (cmd_q == tcpe_pkg::CMD_READ)) begin
			rg_q <= ram_rdata[BYTE_W-1:0];
			rc_q <= ram_rdata[CELL_W-1:BYTE_W];
		end
	end

	// Memory port selection
	always_comb begin
		ram_req = '0;
		if (state_q == S_CLEAR) begin
			ram_req.wen   = 1'b1;
			ram_req.waddr = clr_q;
		end else if (wr_vld_s1) begin
			ram_req.wen   = 1'b1;
			ram_req.waddr = wr_addr_s1;
			ram_req.wdata = wr_src_s1 ? ram_rdata : wr_const_s1;
		end else if ((state_q == S_PT_WR) && is_put) begin
			ram_req.wen   = 1'b1;
			ram_req.waddr = lin_q;
			ram_req.wdata = merged;
		end
		if (state_q == S_WALK) begin
			ram_req.ren   = use_src;
			ram_req.raddr = src_idx;
		end else if (state_q == S_PT_RD) begin
			ram_req.ren   = 1'b1;
			ram_req.raddr = lin_q;
		end
	end

	assign req.ready    = (state_q == S_IDLE);
	assign res.push     = (state_q == S_DONE) && res_free;
	assign res.clearing = (state_q == S_CLEAR);
	assign res.glyph    = rg_q;
	assign res.colour   = rc_q;
	assign res.cursor   = cursor_q;

endmodule

`default_nettype wire

[rtl/text_cell_page_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "text_cell_page_engine_assert.svh"

// Text cell page engine. Holds a page of up to 128 x 32 character cells
// (glyph in the low byte, colour in the high byte) in a single-port-write,
// single-port-read memory and runs one command per item: put, fill, copy,
// clear, clear row, scroll, set cursor and read. Every item returns one
// result carrying the read cell (zero unless a read hits the page) and the
// cursor. After reset the engine sweeps the whole 4096-entry memory to zero,
// one cell a cycle, and takes no command until the sweep ends; configuration
// writes are taken at any time but must only be made while idle. A put or
// read that hits the page passes through setup, start, cell read, cell write
// and done; a put or read off the page, a cursor command and an unused code
// pass through setup, start and done. Fill, copy, clear, clear row and scroll
// walk every cell of the page once and write the cells their box selects
// through the memory write port, or skip the walk on an empty page. A finished
// result waits in an output register while the next command is taken; the
// engine only holds in its done state while an earlier result still waits unaccepted.
module text_cell_page_engine (
	input  logic        clk,
	input  logic        arst_n,
	tcpe_req_if.sink    req,
	tcpe_rsp_if.source  rsp,
	tcpe_cfg_if.sink    cfg
);

	logic [tcpe_pkg::COL_W-1:0]  cols_q, cols_eff;
	logic [tcpe_pkg::ROW_W-1:0]  rows_q, rows_eff;
	logic [tcpe_pkg::CELL_W-1:0] ram_rdata;
	tcpe_pkg::ram_req_t          ram_req;
	tcpe_pkg::seq_res_t          seq_res;

	logic                        rsp_valid_q;
	logic [tcpe_pkg::BYTE_W-1:0] rsp_glyph_q, rsp_colour_q;
	logic [tcpe_pkg::CUR_W-1:0]  rsp_cursor_q;
	logic                        res_free;

	// Page size registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= tcpe_pkg::COLS_RESET;
			rows_q <= tcpe_pkg::ROWS_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				tcpe_pkg::REG_PAGE_COLS: cols_q <= cfg.data[tcpe_pkg::COL_W-1:0];
				tcpe_pkg::REG_PAGE_ROWS: rows_q <= cfg.data[tcpe_pkg::ROW_W-1:0];
			endcase
		end
	end

	// Oversized page clamps to the memory geometry
	assign cols_eff = (cols_q > tcpe_pkg::COL_W'(tcpe_pkg::MAX_COLS))
		? tcpe_pkg::COL_W'(tcpe_pkg::MAX_COLS) : cols_q;
	assign rows_eff = (rows_q > tcpe_pkg::ROW_W'(tcpe_pkg::MAX_ROWS))
		? tcpe_pkg::ROW_W'(tcpe_pkg::MAX_ROWS) : rows_q;

	tcpe_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cols      (cols_eff),
		.rows      (rows_eff),
		.res_free  (res_free),
		.ram_rdata (ram_rdata),
		.ram_req   (ram_req),
		.res       (seq_res)
	);

	tcpe_cell_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	// Output register
	assign res_free = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (seq_res.push) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_res.push) begin
			rsp_glyph_q  <= seq_res.glyph;
			rsp_colour_q <= seq_res.colour;
			rsp_cursor_q <= seq_res.cursor;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.done_res    = 1'b1;
	assign rsp.read_glyph  = rsp_glyph_q;
	assign rsp.read_colour = rsp_colour_q;
	assign rsp.cursor_pos  = rsp_cursor_q;

	// Checks
	`TCPE_ASSERT_IMP(a_no_take_while_clearing, clk, arst_n, seq_res.clearing, !req.ready, "command taken during memory clear")
	`TCPE_ASSERT_NXT(a_busy_after_take, clk, arst_n, req.valid && req.ready, !req.ready, "engine still ready after taking an item")
	`TCPE_ASSERT_IMP(a_no_result_overwrite, clk, arst_n, seq_res.push, !rsp_valid_q || rsp.ready, "result pushed over a waiting result")

endmodule

`default_nettype wire
